// ----- src/bcgd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bcgd_pkg;

    localparam int unsigned TickW  = 16;
    localparam int unsigned TallyW = 4;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [TickW-1:0]  TickMax  = '1;
    localparam logic [TallyW-1:0] TallyMax = '1;

    localparam logic             RstActiveLow = 1'b1;
    localparam logic [TickW-1:0] RstDebounce  = 16'd50;
    localparam logic [TickW-1:0] RstTimeout   = 16'd400;
    localparam logic [TickW-1:0] RstLongPress = 16'd2000;

    typedef enum logic [2:0] {
        G_NONE      = 3'd0,
        G_LONG      = 3'd1,
        G_SINGLE    = 3'd2,
        G_DOUBLE    = 3'd3,
        G_TRIPLE    = 3'd4,
        G_QUADRUPLE = 3'd5,
        G_MANY      = 3'd6
    } t_gesture;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_ACTIVE_LOW = 2'd0,
        CFG_DEBOUNCE   = 2'd1,
        CFG_TIMEOUT    = 2'd2,
        CFG_LONG_PRESS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic             active_low;
        logic [TickW-1:0] debounce;
        logic [TickW-1:0] timeout;
        logic [TickW-1:0] long_press;
    } t_cfg;

    typedef struct packed {
        t_gesture gesture;
        logic     input_busy;
    } t_result;

    function automatic logic [TickW-1:0] sat_inc(input logic [TickW-1:0] t);
        return (t == TickMax) ? t : t + 1'b1;
    endfunction

    function automatic t_gesture tally_gesture(input logic [TallyW-1:0] n);
        t_gesture g;
        if (n >= 4'd5) begin
            g = G_MANY;
        end else begin
            g = t_gesture'(n[2:0] + 3'd1);
        end
        return g;
    endfunction

endpackage
`default_nettype wire

// ----- src/button_click_gesture_detector.sv -----
// Button gesture detector: debounce, multi-click count and long press.
// Input channel: one request per millisecond tick carrying the raw pin level
//   (i_in_valid / o_in_stall). Accepted when valid is high and stall is low.
// Output channel: one result per request, o_gesture and o_input_busy
//   (o_out_valid / i_out_stall).
// Config channel: i_cfg_valid / o_cfg_ready with register index and data;
//   ready is always high. Write only while no request is in flight.
// Result: registered in the output register, or in the skid while stalled.
// Throughput: one request per cycle unless o_in_stall is high; the state
//   update's counters and compares are combinational up to the output register.
// Stall: a two-entry output buffer (output register plus skid) absorbs one
//   request while the receiver stalls; o_in_stall rises when the skid fills.
// Reset: synchronous, active low. Config returns to active low, 50 ms
//   debounce, 400 ms click timeout, 2000 ms long press; all gesture state
//   clears and the button is taken as released.
`timescale 1ns / 1ps
`default_nettype none
module button_click_gesture_detector (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_raw_level,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [2:0]                         o_gesture,
    output logic                               o_input_busy,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [bcgd_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [bcgd_pkg::TickW-1:0]    i_cfg_data
);

    bcgd_pkg::t_cfg    cfg;
    bcgd_pkg::t_result core_result;
    bcgd_pkg::t_result out_result;
    logic              push;
    logic              full;

    assign o_cfg_ready = 1'b1;
    assign push        = i_in_valid && !full;
    assign o_in_stall  = full;

    bcgd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bcgd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_raw_level (i_raw_level),
        .i_cfg       (cfg),
        .o_result    (core_result)
    );

    bcgd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_result    (core_result),
        .o_full      (full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (out_result)
    );

    assign o_gesture    = out_result.gesture;
    assign o_input_busy = out_result.input_busy;

endmodule
`default_nettype wire

// ----- src/bcgd_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bcgd_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [bcgd_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [bcgd_pkg::TickW-1:0]    i_cfg_data,
    output bcgd_pkg::t_cfg                     o_cfg
);

    bcgd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low <= bcgd_pkg::RstActiveLow;
            r_cfg.debounce   <= bcgd_pkg::RstDebounce;
            r_cfg.timeout    <= bcgd_pkg::RstTimeout;
            r_cfg.long_press <= bcgd_pkg::RstLongPress;
        end else if (i_cfg_valid) begin
            unique case (bcgd_pkg::t_cfg_idx'(i_cfg_index))
                bcgd_pkg::CFG_ACTIVE_LOW: r_cfg.active_low <= i_cfg_data[0];
                bcgd_pkg::CFG_DEBOUNCE:   r_cfg.debounce   <= i_cfg_data;
                bcgd_pkg::CFG_TIMEOUT:    r_cfg.timeout    <= i_cfg_data;
                bcgd_pkg::CFG_LONG_PRESS: r_cfg.long_press <= i_cfg_data;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- src/bcgd_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bcgd_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire logic           i_raw_level,
    input  wire bcgd_pkg::t_cfg i_cfg,
    output bcgd_pkg::t_result   o_result
);

    logic                           r_prev_level, n_prev_level;
    logic [bcgd_pkg::TickW-1:0]     r_since_change, n_since_change;
    logic [bcgd_pkg::TickW-1:0]     r_since_press, n_since_press;
    logic [bcgd_pkg::TickW-1:0]     r_since_click, n_since_click;
    logic                           r_held, n_held;
    logic                           r_long_rep, n_long_rep;
    logic [bcgd_pkg::TallyW-1:0]    r_tally, n_tally;
    logic                           r_busy, n_busy;
    bcgd_pkg::t_gesture             gesture;
    logic                           level;

    always_comb begin
        level          = i_raw_level ^ i_cfg.active_low;
        n_prev_level   = level;
        n_since_press  = bcgd_pkg::sat_inc(r_since_press);
        n_since_click  = bcgd_pkg::sat_inc(r_since_click);
        n_since_change = (level != r_prev_level) ? '0 : bcgd_pkg::sat_inc(r_since_change);
        n_held         = r_held;
        n_long_rep     = r_long_rep;
        n_tally        = r_tally;
        n_busy         = r_busy;
        gesture        = bcgd_pkg::G_NONE;

        if (n_since_change > i_cfg.debounce) begin
            if (level && !r_held) begin
                n_held        = 1'b1;
                n_since_press = '0;
                n_long_rep    = 1'b0;
                if (r_tally != bcgd_pkg::TallyMax) begin
                    n_tally = r_tally + 1'b1;
                end
                n_since_click = '0;
                n_busy        = 1'b1;
            end else if (!level && r_held) begin
                n_held = 1'b0;
                if (!r_long_rep) begin
                    if (n_since_click > i_cfg.timeout && r_tally != '0) begin
                        gesture = bcgd_pkg::tally_gesture(r_tally);
                        n_busy  = 1'b0;
                        n_tally = '0;
                    end
                end else begin
                    n_tally = '0;
                end
            end

            if (n_held && !n_long_rep && n_since_press >= i_cfg.long_press) begin
                n_long_rep = 1'b1;
                gesture    = bcgd_pkg::G_LONG;
                n_busy     = 1'b0;
            end

            if (!n_held && n_since_click > i_cfg.timeout && n_tally != '0) begin
                gesture = bcgd_pkg::tally_gesture(n_tally);
                n_busy  = 1'b0;
                n_tally = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level   <= 1'b0;
            r_since_change <= '0;
            r_since_press  <= '0;
            r_since_click  <= '0;
            r_held         <= 1'b0;
            r_long_rep     <= 1'b0;
            r_tally        <= '0;
            r_busy         <= 1'b0;
        end else if (i_push) begin
            r_prev_level   <= n_prev_level;
            r_since_change <= n_since_change;
            r_since_press  <= n_since_press;
            r_since_click  <= n_since_click;
            r_held         <= n_held;
            r_long_rep     <= n_long_rep;
            r_tally        <= n_tally;
            r_busy         <= n_busy;
        end
    end

    assign o_result = '{gesture: gesture, input_busy: n_busy};

endmodule
`default_nettype wire

// ----- src/bcgd_out.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bcgd_out (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire bcgd_pkg::t_result i_result,
    output logic                   o_full,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output bcgd_pkg::t_result      o_result
);

    logic              r_out_valid;
    bcgd_pkg::t_result r_out;
    logic              r_skid_valid;
    bcgd_pkg::t_result r_skid;

    // skid holds one request when the output register is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_result;
            end
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic                         i_raw_level;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic [2:0]                   o_gesture;
    logic                         o_input_busy;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [bcgd_pkg::CfgIdxW-1:0] i_cfg_index;
    logic [bcgd_pkg::TickW-1:0]   i_cfg_data;

    button_click_gesture_detector i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_raw_level  (i_raw_level),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_gesture    (o_gesture),
        .o_input_busy (o_input_busy),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // gesture tracker state
    bcgd_pkg::t_cfg              cfg_m;
    logic                        prev_lvl;
    logic                        held_q;
    logic                        long_done;
    logic                        busy_q;
    logic [bcgd_pkg::TickW-1:0]  since_change;
    logic [bcgd_pkg::TickW-1:0]  since_press;
    logic [bcgd_pkg::TickW-1:0]  since_click;
    logic [bcgd_pkg::TallyW-1:0] tally;

    bcgd_pkg::t_result pending_results[$];

    int errors          = 0;
    int ticks_sent      = 0;
    int results_checked = 0;
    int stall_seen      = 0;
    int phase_ticks     = 0;
    int hold_len        = 0;
    int gesture_hits[7] = '{default: 0};
    bit send_gaps       = 1'b1;
    bit recv_gaps       = 1'b1;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic logic [bcgd_pkg::TickW-1:0] bump(input logic [bcgd_pkg::TickW-1:0] t);
        return (&t) ? t : t + 16'd1;
    endfunction

    function automatic bcgd_pkg::t_gesture clicks_to_gesture(
        input logic [bcgd_pkg::TallyW-1:0] n);
        case (n)
            4'd1:    return bcgd_pkg::G_SINGLE;
            4'd2:    return bcgd_pkg::G_DOUBLE;
            4'd3:    return bcgd_pkg::G_TRIPLE;
            4'd4:    return bcgd_pkg::G_QUADRUPLE;
            default: return bcgd_pkg::G_MANY;
        endcase
    endfunction

    task automatic model_reset();
        cfg_m.active_low = bcgd_pkg::RstActiveLow;
        cfg_m.debounce   = bcgd_pkg::RstDebounce;
        cfg_m.timeout    = bcgd_pkg::RstTimeout;
        cfg_m.long_press = bcgd_pkg::RstLongPress;
        prev_lvl     = 1'b0;
        held_q       = 1'b0;
        long_done    = 1'b0;
        busy_q       = 1'b0;
        since_change = '0;
        since_press  = '0;
        since_click  = '0;
        tally        = '0;
    endtask

    task automatic model_tick(input logic raw, output bcgd_pkg::t_result r);
        logic               lvl;
        bcgd_pkg::t_gesture g;
        lvl = raw ^ cfg_m.active_low;
        g = bcgd_pkg::G_NONE;
        since_press = bump(since_press);
        since_click = bump(since_click);
        since_change = (lvl != prev_lvl) ? '0 : bump(since_change);
        if (since_change > cfg_m.debounce) begin
            if (lvl && !held_q) begin
                held_q = 1'b1;
                since_press = '0;
                long_done = 1'b0;
                if (tally != bcgd_pkg::TallyMax) tally = tally + 1'b1;
                since_click = '0;
                busy_q = 1'b1;
            end else if (!lvl && held_q) begin
                held_q = 1'b0;
                // a release after a long press drops the count
                if (long_done) tally = '0;
            end
            if (held_q && !long_done && since_press >= cfg_m.long_press) begin
                long_done = 1'b1;
                g = bcgd_pkg::G_LONG;
                busy_q = 1'b0;
            end
            if (!held_q && since_click > cfg_m.timeout && tally != 0) begin
                g = clicks_to_gesture(tally);
                busy_q = 1'b0;
                tally = '0;
            end
        end
        prev_lvl = lvl;
        r.gesture = g;
        r.input_busy = busy_q;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 20)
            $display("tb: mismatch on %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    always @(posedge i_clk) begin : check_results
        bcgd_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_gesture, -1);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                gesture_hits[int'(want.gesture)]++;
                if (o_gesture !== want.gesture)
                    report_mismatch("gesture", o_gesture, want.gesture);
                if (o_input_busy !== want.input_busy)
                    report_mismatch("input_busy", o_input_busy, want.input_busy);
            end
        end
    end

    initial begin : receiver
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_len = 0;
            end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic push_tick(input logic raw);
        bcgd_pkg::t_result r;
        if (send_gaps && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_raw_level <= raw;
        @(posedge i_clk);
        while (o_in_stall) begin
            stall_seen++;
            @(posedge i_clk);
        end
        model_tick(raw, r);
        pending_results.push_back(r);
        ticks_sent++;
        phase_ticks++;
    endtask

    task automatic send_level(input logic pressed, input int n);
        repeat (n) push_tick(pressed ^ cfg_m.active_low);
    endtask

    task automatic pause_sender();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_apply(input logic al, input logic [bcgd_pkg::TickW-1:0] deb,
                             input logic [bcgd_pkg::TickW-1:0] tmo,
                             input logic [bcgd_pkg::TickW-1:0] lp);
        bcgd_pkg::t_cfg_idx         order[4];
        logic [bcgd_pkg::TickW-1:0] vals[4];
        order = '{bcgd_pkg::CFG_ACTIVE_LOW, bcgd_pkg::CFG_DEBOUNCE,
                  bcgd_pkg::CFG_TIMEOUT, bcgd_pkg::CFG_LONG_PRESS};
        vals  = '{{15'd0, al}, deb, tmo, lp};
        pause_sender();
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= order[k];
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (order[k])
                bcgd_pkg::CFG_ACTIVE_LOW: cfg_m.active_low = vals[k][0];
                bcgd_pkg::CFG_DEBOUNCE:   cfg_m.debounce   = vals[k];
                bcgd_pkg::CFG_TIMEOUT:    cfg_m.timeout    = vals[k];
                bcgd_pkg::CFG_LONG_PRESS: cfg_m.long_press = vals[k];
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_level();
        send_level(1'b0, 3);
        send_level(1'b1, 2);
    endtask

    task automatic test_single_click();
        cfg_apply(1'b0, 16'd0, 16'd0, 16'hFFFF);
        send_level(1'b1, 2);
        send_level(1'b0, 2);
    endtask

    task automatic test_long_press_zero();
        // long press fires on the press tick, release then drops the count
        cfg_apply(1'b1, 16'd0, 16'd2, 16'd0);
        send_level(1'b1, 2);
        send_level(1'b0, 3);
    endtask

    task automatic test_tally_saturation();
        cfg_apply(1'b0, 16'd0, 16'd3, 16'hFFFF);
        repeat (17) begin
            send_level(1'b1, 2);
            send_level(1'b0, 2);
        end
        send_level(1'b0, 4);
    endtask

    task automatic test_backpressure();
        cfg_apply(1'b1, 16'd1, 16'd4, 16'd10);
        recv_gaps = 1'b0;
        hold_len = 40;
        repeat (6) begin
            send_level(1'b1, 3);
            send_level(1'b0, 3);
        end
        recv_gaps = 1'b1;
        pause_sender();
    endtask

    task automatic test_large_limits();
        cfg_apply(1'b1, 16'd0, 16'hFFFE, 16'hFFFF);
        send_level(1'b1, 2);
        send_level(1'b0, 40);
        // a debounce at max holds every level back
        cfg_apply(1'b1, 16'hFFFF, 16'd0, 16'd1);
        send_level(1'b1, 40);
        send_level(1'b0, 40);
    endtask

    task automatic random_episode();
        int kind;
        int clicks;
        int deb;
        int tmo;
        int lp;
        bit go_long;
        deb = cfg_m.debounce;
        tmo = cfg_m.timeout;
        lp  = cfg_m.long_press;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 6)) push_tick(1'($urandom_range(0, 1)));
        end else if (kind == 1) begin
            send_level(1'b1, $urandom_range(1, deb + 1));
            send_level(1'b0, $urandom_range(1, deb + 1));
        end else begin
            clicks = (kind == 2) ? $urandom_range(5, 17) : $urandom_range(1, 4);
            for (int c = 0; c < clicks; c++) begin
                go_long = (c == clicks - 1) && (lp <= 64) && ($urandom_range(0, 3) == 0);
                send_level(1'b1, deb + 1 + (go_long ? lp : 0) + $urandom_range(0, 3));
                send_level(1'b0, deb + 1 + $urandom_range(0, (tmo < 16) ? tmo : 16));
            end
            send_level(1'b0, deb + ((tmo < 40) ? tmo : 40) + $urandom_range(0, 3));
        end
    endtask

    task automatic test_random_gestures();
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: cfg_apply(1'b0, 16'd0, 16'd0, 16'd1);
                1: cfg_apply(1'b1, 16'd0, 16'hFFFF, 16'hFFFF);
                default: cfg_apply(1'($urandom_range(0, 1)), 16'($urandom_range(0, 3)),
                                   16'($urandom_range(0, 12)), 16'($urandom_range(1, 40)));
            endcase
            if (p == 6) begin
                send_gaps = 1'b0;
                recv_gaps = 1'b0;
            end
            phase_ticks = 0;
            while (phase_ticks < 200) random_episode();
        end
    endtask

    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_raw_level = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = bcgd_pkg::CFG_ACTIVE_LOW;
        i_cfg_data  = '0;
        model_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_level();
        test_single_click();
        test_long_press_zero();
        test_tally_saturation();
        test_backpressure();
        test_large_limits();
        test_random_gestures();

        pause_sender();
        repeat (8) @(posedge i_clk);
        $display("summary: %0d ticks, %0d results checked, %0d cycles with input stalled",
                 ticks_sent, results_checked, stall_seen);
        $display("summary: long %0d, 1x %0d, 2x %0d, 3x %0d, 4x %0d, 5+ %0d; %0d mismatches",
                 gesture_hits[1], gesture_hits[2], gesture_hits[3], gesture_hits[4],
                 gesture_hits[5], gesture_hits[6], errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
